FILE: hw/rtl/rdd_pkg.sv
package rdd_pkg;

  // Operation codes of an input word
  typedef enum logic [2:0] {
    OP_ACQUIRE  = 3'd0,
    OP_RELEASE  = 3'd1,
    OP_REFCOUNT = 3'd2,
    OP_EXISTS   = 3'd3,
    OP_ENTRY    = 3'd4,
    OP_PURGE    = 3'd5,
    OP_STATS    = 3'd6,
    OP_CLEAR    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CANON       = 2'd2;

  localparam logic [6:0]  MAX_ENTRIES_RST = 7'd64;
  localparam logic [31:0] ONE_BITS        = 32'h3F80_0000;
  localparam logic [31:0] REFS_MAX        = 32'hFFFF_FFFF;
  localparam int unsigned MIP_LSB         = 16;

  typedef struct packed {
    op_e         operation;
    logic [31:0] handle_in;
    logic [63:0] mode_bytes;
    logic        aniso_enable;
    logic        unnormalized_coords;
    logic [31:0] lod_bias_bits;
    logic [31:0] max_aniso_bits;
    logic [31:0] min_lod_bits;
    logic [31:0] max_lod_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] handle_out;
    status_e     status;
    logic [31:0] ref_count;
    logic        found;
    logic [5:0]  slot_index;
    logic [6:0]  purged_count;
    logic [6:0]  live_count;
    logic [6:0]  peak_count;
    logic [31:0] acquire_total;
    logic [31:0] dedup_total;
    logic [31:0] release_total;
    logic [31:0] destroyed_total;
  } out_t;

  typedef struct packed {
    logic [6:0] max_entries;
    logic       ref_counting_enable;
    logic       canonicalize_enable;
  } cfg_t;

  // Stored descriptor: flags are {unnormalized, aniso}
  typedef struct packed {
    logic [63:0] modes;
    logic [1:0]  flags;
    logic [31:0] lod_bias;
    logic [31:0] aniso;
    logic [31:0] min_lod;
    logic [31:0] max_lod;
  } desc_t;

  typedef struct packed {
    desc_t       desc;
    logic [31:0] handle;
    logic [31:0] refs;
    logic [5:0]  slot;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // take the input word
    logic scan_rd; // read the next table entry
    logic commit;  // apply the operation and emit the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

FILE: hw/rtl/rdd_ctrl.sv
module rdd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  rdd_pkg::op_e   in_op_i,
  input  logic           out_free_i,
  input  rdd_pkg::sts_t  sts_i,
  output logic           in_ready_o,
  output rdd_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.scan_rd = 1'b0;
    cmd_o.commit  = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // stats and clear need no table scan
          if (in_op_i == rdd_pkg::OP_STATS || in_op_i == rdd_pkg::OP_CLEAR) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  chk_commit_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> in_ready_o)
    else $error("commit did not return to idle");

endmodule

FILE: hw/rtl/rdd_datapath.sv
module rdd_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rdd_pkg::cmd_t  cmd_i,
  input  rdd_pkg::in_t   in_i,
  input  rdd_pkg::cfg_t  cfg_i,
  output rdd_pkg::sts_t  sts_o,
  output rdd_pkg::out_t  res_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

  // Held word
  rdd_pkg::op_e  op_q;
  logic [31:0]   h_q;
  rdd_pkg::desc_t desc_q, desc_d;

  // Table storage
  rdd_pkg::entry_t mem [TABLE_DEPTH];
  rdd_pkg::entry_t rd_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  // Scan
  logic [IDX_W-1:0] scan_idx_q, chk_idx_q;
  logic             chk_q;
  logic             hit_q, free_found_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  rdd_pkg::entry_t  hit_ent_q;

  // Counters
  logic [CNT_W-1:0] live_q, peak_q, purged_q, live_d, peak_d;
  logic [31:0]      nh_q, nh_d;
  logic [31:0]      acq_q, dedup_q, rel_q, destr_q;
  logic [31:0]      acq_d, dedup_d, rel_d, destr_d;

  // Commit controls
  logic             wr_en, set_valid, clr_valid, clr_all;
  logic [IDX_W-1:0] wr_idx;
  rdd_pkg::entry_t  wr_ent;
  logic [31:0]      new_refs;
  logic [CMP_W-1:0] cap;

  // Scan compare
  logic chk_v, desc_eq, h_eq, match, purge_ev;

  assign sts_o.scan_last = (scan_idx_q == IDX_W'(TABLE_DEPTH - 1));

  // Canonicalize on load
  always_comb begin
    desc_d.modes    = in_i.mode_bytes;
    desc_d.flags    = {in_i.unnormalized_coords, in_i.aniso_enable};
    desc_d.lod_bias = in_i.lod_bias_bits;
    desc_d.aniso    = in_i.max_aniso_bits;
    desc_d.min_lod  = in_i.min_lod_bits;
    desc_d.max_lod  = in_i.max_lod_bits;
    if (cfg_i.canonicalize_enable &&
        (in_i.operation == rdd_pkg::OP_ACQUIRE || in_i.operation == rdd_pkg::OP_EXISTS)) begin
      if (!in_i.aniso_enable) begin
        desc_d.aniso = rdd_pkg::ONE_BITS;
      end
      if (in_i.unnormalized_coords) begin
        desc_d.modes[rdd_pkg::MIP_LSB +: 8] = 8'd0;
        desc_d.min_lod = 32'd0;
        desc_d.max_lod = 32'd0;
      end
    end
  end

  assign chk_v   = valid_q[chk_idx_q];
  assign desc_eq = chk_v && (rd_q.desc == desc_q);
  assign h_eq    = chk_v && (h_q != 32'd0) && (rd_q.handle == h_q);
  assign match   = chk_q && ((op_q == rdd_pkg::OP_ACQUIRE || op_q == rdd_pkg::OP_EXISTS)
                             ? desc_eq : h_eq);
  assign purge_ev = chk_q && chk_v && (op_q == rdd_pkg::OP_PURGE) && (rd_q.refs == 32'd0);

  assign cap = (CMP_W'(cfg_i.max_entries) < CMP_W'(TABLE_DEPTH))
               ? CMP_W'(cfg_i.max_entries) : CMP_W'(TABLE_DEPTH);

  // Resolve the operation from the scan outcome
  always_comb begin
    live_d    = live_q;
    peak_d    = peak_q;
    nh_d      = nh_q;
    acq_d     = acq_q;
    dedup_d   = dedup_q;
    rel_d     = rel_q;
    destr_d   = destr_q;
    wr_en     = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    clr_all   = 1'b0;
    wr_idx    = hit_idx_q;
    wr_ent    = hit_ent_q;
    new_refs  = hit_ent_q.refs;
    res_o.handle_out = 32'd0;
    res_o.status     = rdd_pkg::ST_OK;
    res_o.ref_count  = 32'd0;
    res_o.found      = 1'b0;
    res_o.slot_index = 6'd0;
    case (op_q)
      rdd_pkg::OP_ACQUIRE: begin
        acq_d = acq_q + 32'd1;
        if (hit_q) begin
          if (cfg_i.ref_counting_enable && hit_ent_q.refs != rdd_pkg::REFS_MAX) begin
            new_refs = hit_ent_q.refs + 32'd1;
          end
          wr_en       = 1'b1;
          wr_ent.refs = new_refs;
          dedup_d     = dedup_q + 32'd1;
          res_o.found      = 1'b1;
          res_o.handle_out = hit_ent_q.handle;
          res_o.ref_count  = new_refs;
          res_o.slot_index = hit_ent_q.slot;
        end else if (CMP_W'(live_q) >= cap) begin
          res_o.status = rdd_pkg::ST_FULL;
        end else if (nh_q == 32'd0) begin
          res_o.status = rdd_pkg::ST_EXHAUSTED;
        end else if (!free_found_q) begin
          res_o.status = rdd_pkg::ST_FULL;
        end else begin
          wr_en        = 1'b1;
          set_valid    = 1'b1;
          wr_idx       = free_idx_q;
          wr_ent.desc  = desc_q;
          wr_ent.handle = nh_q;
          wr_ent.refs  = 32'd1;
          wr_ent.slot  = 6'(live_q);
          nh_d   = nh_q + 32'd1;
          live_d = live_q + CNT_W'(1);
          if (live_d > peak_q) begin
            peak_d = live_d;
          end
          res_o.handle_out = nh_q;
          res_o.ref_count  = 32'd1;
          res_o.slot_index = 6'(live_q);
        end
      end
      rdd_pkg::OP_RELEASE: begin
        rel_d = rel_q + 32'd1;
        if (!hit_q) begin
          res_o.status = rdd_pkg::ST_UNKNOWN;
        end else begin
          if (cfg_i.ref_counting_enable) begin
            if (hit_ent_q.refs != 32'd0) begin
              new_refs = hit_ent_q.refs - 32'd1;
            end
            wr_en       = 1'b1;
            wr_ent.refs = new_refs;
            if (new_refs == 32'd0) begin
              clr_valid = 1'b1;
              live_d    = live_q - CNT_W'(1);
              destr_d   = destr_q + 32'd1;
            end
          end
          res_o.found      = 1'b1;
          res_o.handle_out = hit_ent_q.handle;
          res_o.ref_count  = new_refs;
          res_o.slot_index = hit_ent_q.slot;
        end
      end
      rdd_pkg::OP_REFCOUNT, rdd_pkg::OP_ENTRY: begin
        if (!hit_q) begin
          res_o.status = rdd_pkg::ST_UNKNOWN;
        end else begin
          res_o.found      = 1'b1;
          res_o.handle_out = hit_ent_q.handle;
          res_o.ref_count  = hit_ent_q.refs;
          res_o.slot_index = hit_ent_q.slot;
        end
      end
      rdd_pkg::OP_EXISTS: begin
        if (hit_q) begin
          res_o.found      = 1'b1;
          res_o.handle_out = hit_ent_q.handle;
          res_o.ref_count  = hit_ent_q.refs;
          res_o.slot_index = hit_ent_q.slot;
        end
      end
      rdd_pkg::OP_CLEAR: begin
        clr_all = 1'b1;
        live_d  = '0;
        peak_d  = '0;
        nh_d    = 32'd1;
        acq_d   = 32'd0;
        dedup_d = 32'd0;
        rel_d   = 32'd0;
        destr_d = 32'd0;
      end
      default: ;
    endcase
    res_o.purged_count    = 7'(purged_q);
    res_o.live_count      = 7'(live_d);
    res_o.peak_count      = 7'(peak_d);
    res_o.acquire_total   = acq_d;
    res_o.dedup_total     = dedup_d;
    res_o.release_total   = rel_d;
    res_o.destroyed_total = destr_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= rdd_pkg::OP_STATS;
      valid_q      <= '0;
      scan_idx_q   <= '0;
      chk_q        <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      live_q       <= '0;
      peak_q       <= '0;
      purged_q     <= '0;
      nh_q         <= 32'd1;
      acq_q        <= 32'd0;
      dedup_q      <= 32'd0;
      rel_q        <= 32'd0;
      destr_q      <= 32'd0;
    end else begin
      chk_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        op_q         <= in_i.operation;
        scan_idx_q   <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        purged_q     <= '0;
      end else if (cmd_i.commit) begin
        live_q  <= live_d;
        peak_q  <= peak_d;
        nh_q    <= nh_d;
        acq_q   <= acq_d;
        dedup_q <= dedup_d;
        rel_q   <= rel_d;
        destr_q <= destr_d;
        if (clr_all) begin
          valid_q <= '0;
        end else if (set_valid) begin
          valid_q[wr_idx] <= 1'b1;
        end else if (clr_valid) begin
          valid_q[wr_idx] <= 1'b0;
        end
      end else begin
        if (cmd_i.scan_rd) begin
          scan_idx_q <= scan_idx_q + IDX_W'(1);
        end
        if (match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (chk_q && !chk_v && !free_found_q) begin
          free_found_q <= 1'b1;
        end
        // drop idle entries as the purge sweep passes them
        if (purge_ev) begin
          valid_q[chk_idx_q] <= 1'b0;
          purged_q <= purged_q + CNT_W'(1);
          live_q   <= live_q - CNT_W'(1);
          destr_q  <= destr_q + 32'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q    <= in_i.handle_in;
      desc_q <= desc_d;
    end
    chk_idx_q <= scan_idx_q;
    if (match && !hit_q) begin
      hit_idx_q <= chk_idx_q;
      hit_ent_q <= rd_q;
    end
    if (chk_q && !chk_v && !free_found_q) begin
      free_idx_q <= chk_idx_q;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    if (cmd_i.scan_rd) begin
      rd_q <= mem[scan_idx_q];
    end
  end

  chk_live_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(live_q))
    else $error("live count disagrees with valid entries");

  chk_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= live_q || (cmd_i.commit && op_q == rdd_pkg::OP_CLEAR) ||
    $past(cmd_i.commit && op_q == rdd_pkg::OP_CLEAR) || peak_q >= live_q)
    else $error("peak below live count");

  chk_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(TABLE_DEPTH))
    else $error("live count beyond table depth");

endmodule

FILE: hw/rtl/refcounted_descriptor_dedup_table.sv
// Lookup ops: after accept the table is scanned, one entry read per cycle, then
//   compared, and the commit waits for a free result slot; stats and clear skip
//   the scan. No new input word is taken until the current one commits; the
//   result register can be taken by the receiver meanwhile.
// Reset (async, active low): table empty, next handle 1, counters zero, max_entries 64,
//   ref counting and canonicalization on. No clearing pass is needed.
module refcounted_descriptor_dedup_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rdd_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rdd_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rdd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rdd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  rdd_pkg::cfg_t cfg_q;
  rdd_pkg::cmd_t cmd;
  rdd_pkg::sts_t sts;
  rdd_pkg::out_t res;
  rdd_pkg::out_t out_q;
  logic          out_valid_q;
  logic          out_free;

  // Configuration writes land at once; indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_entries         <= rdd_pkg::MAX_ENTRIES_RST;
      cfg_q.ref_counting_enable <= 1'b1;
      cfg_q.canonicalize_enable <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rdd_pkg::CFG_MAX_ENTRIES: cfg_q.max_entries         <= cfg_data_i[6:0];
        rdd_pkg::CFG_REF_COUNT:   cfg_q.ref_counting_enable <= cfg_data_i[0];
        rdd_pkg::CFG_CANON:       cfg_q.canonicalize_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Result word slot: the commit waits until it is empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  rdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rdd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_data_i),
    .cfg_i  (cfg_q),
    .sts_o  (sts),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the word until taken
  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  chk_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten before it was taken");

endmodule

FILE: verif/tb_refcounted_descriptor_dedup_table.sv
module tb_refcounted_descriptor_dedup_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DRAIN_WAIT = DEPTH + 8;   // one full table scan plus margin
  localparam int unsigned CYCLE_CAP  = 2_000_000;
  localparam int unsigned POOL_MAX   = 96;

  // Shadow of the descriptor table: predicts every result word and keeps
  // the words still owed by the block in arrival order.
  class desc_table_scoreboard;
    rdd_pkg::entry_t slots [DEPTH];
    bit              used  [DEPTH];
    logic [31:0]     next_handle;
    int              live, peak;
    logic [31:0]     n_acquire, n_dedup, n_release, n_destroyed;
    rdd_pkg::cfg_t   cfg;
    rdd_pkg::out_t   owed_words[$];
    int              errors;

    function new();
      cfg.max_entries         = rdd_pkg::MAX_ENTRIES_RST;
      cfg.ref_counting_enable = 1'b1;
      cfg.canonicalize_enable = 1'b1;
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      foreach (used[i]) used[i] = 1'b0;
      next_handle = 32'd1;
      live        = 0;
      peak        = 0;
      n_acquire   = '0;
      n_dedup     = '0;
      n_release   = '0;
      n_destroyed = '0;
    endfunction

    function void write_reg(logic [rdd_pkg::CFG_IDX_W-1:0] idx,
                            logic [rdd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rdd_pkg::CFG_MAX_ENTRIES: cfg.max_entries         = val[6:0];
        rdd_pkg::CFG_REF_COUNT:   cfg.ref_counting_enable = val[0];
        rdd_pkg::CFG_CANON:       cfg.canonicalize_enable = val[0];
        default: ;  // unmapped index: drop
      endcase
    endfunction

    function int find_desc(rdd_pkg::desc_t d);
      for (int i = 0; i < DEPTH; i++)
        if (used[i] && slots[i].desc == d) return i;
      return -1;
    endfunction

    function int find_handle(logic [31:0] h);
      if (h == 32'd0) return -1;
      for (int i = 0; i < DEPTH; i++)
        if (used[i] && slots[i].handle == h) return i;
      return -1;
    endfunction

    function void evict(int i);
      used[i] = 1'b0;
      live--;
      n_destroyed++;
    endfunction

    // Handle of a random live entry, or the next one to be issued.
    function logic [31:0] live_handle();
      int cand[$];
      for (int i = 0; i < DEPTH; i++) if (used[i]) cand.push_back(i);
      if (cand.size() == 0) return next_handle;
      return slots[cand[$urandom_range(cand.size() - 1)]].handle;
    endfunction

    function void fill_hit(ref rdd_pkg::out_t r, input int i);
      r.found      = 1'b1;
      r.handle_out = slots[i].handle;
      r.ref_count  = slots[i].refs;
      r.slot_index = slots[i].slot;
    endfunction

    // Work out the result of one accepted input word and queue it.
    function void note_input(rdd_pkg::in_t w);
      rdd_pkg::desc_t d;
      rdd_pkg::out_t  r;
      int             i, cap;
      d.modes    = w.mode_bytes;
      d.flags    = {w.unnormalized_coords, w.aniso_enable};
      d.lod_bias = w.lod_bias_bits;
      d.aniso    = w.max_aniso_bits;
      d.min_lod  = w.min_lod_bits;
      d.max_lod  = w.max_lod_bits;
      if (cfg.canonicalize_enable &&
          (w.operation == rdd_pkg::OP_ACQUIRE || w.operation == rdd_pkg::OP_EXISTS)) begin
        if (!w.aniso_enable) d.aniso = rdd_pkg::ONE_BITS;
        if (w.unnormalized_coords) begin
          d.modes[rdd_pkg::MIP_LSB +: 8] = 8'd0;
          d.min_lod = '0;
          d.max_lod = '0;
        end
      end
      cap = (cfg.max_entries < DEPTH) ? int'(cfg.max_entries) : int'(DEPTH);
      r = '0;
      r.status = rdd_pkg::ST_OK;
      case (w.operation)
        rdd_pkg::OP_ACQUIRE: begin
          n_acquire++;
          i = find_desc(d);
          if (i >= 0) begin
            if (cfg.ref_counting_enable && slots[i].refs != rdd_pkg::REFS_MAX) slots[i].refs++;
            n_dedup++;
            fill_hit(r, i);
          end else if (live >= cap) begin
            r.status = rdd_pkg::ST_FULL;
          end else if (next_handle == 32'd0) begin
            r.status = rdd_pkg::ST_EXHAUSTED;
          end else begin
            // lowest free slot; cap <= DEPTH guarantees one exists here
            for (i = 0; i < DEPTH && used[i]; i++) ;
            used[i]        = 1'b1;
            slots[i].desc  = d;
            slots[i].handle = next_handle;
            slots[i].refs  = 32'd1;
            slots[i].slot  = live[5:0];
            next_handle++;
            live++;
            if (live > peak) peak = live;
            r.handle_out = slots[i].handle;
            r.ref_count  = 32'd1;
            r.slot_index = slots[i].slot;
          end
        end
        rdd_pkg::OP_RELEASE: begin
          n_release++;
          i = find_handle(w.handle_in);
          if (i < 0) begin
            r.status = rdd_pkg::ST_UNKNOWN;
          end else begin
            r.found      = 1'b1;
            r.handle_out = slots[i].handle;
            r.slot_index = slots[i].slot;
            if (cfg.ref_counting_enable) begin
              if (slots[i].refs != 0) slots[i].refs--;
              if (slots[i].refs == 0) evict(i);
            end
            r.ref_count = slots[i].refs;
          end
        end
        rdd_pkg::OP_REFCOUNT, rdd_pkg::OP_ENTRY: begin
          i = find_handle(w.handle_in);
          if (i < 0) r.status = rdd_pkg::ST_UNKNOWN;
          else fill_hit(r, i);
        end
        rdd_pkg::OP_EXISTS: begin
          i = find_desc(d);
          if (i >= 0) fill_hit(r, i);
        end
        rdd_pkg::OP_PURGE: begin
          for (i = 0; i < DEPTH; i++)
            if (used[i] && slots[i].refs == 0) begin
              evict(i);
              r.purged_count++;
            end
        end
        rdd_pkg::OP_STATS: ;
        default: wipe();
      endcase
      r.live_count      = live[6:0];
      r.peak_count      = peak[6:0];
      r.acquire_total   = n_acquire;
      r.dedup_total     = n_dedup;
      r.release_total   = n_release;
      r.destroyed_total = n_destroyed;
      owed_words.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task cmp(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s: got %0h, expected %0h", field, got, want));
    endtask

    task check_result(rdd_pkg::out_t got);
      rdd_pkg::out_t e;
      if (owed_words.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = owed_words.pop_front();
      cmp("handle_out",      got.handle_out,      e.handle_out);
      cmp("status",          got.status,          e.status);
      cmp("ref_count",       got.ref_count,       e.ref_count);
      cmp("found",           got.found,           e.found);
      cmp("slot_index",      got.slot_index,      e.slot_index);
      cmp("purged_count",    got.purged_count,    e.purged_count);
      cmp("live_count",      got.live_count,      e.live_count);
      cmp("peak_count",      got.peak_count,      e.peak_count);
      cmp("acquire_total",   got.acquire_total,   e.acquire_total);
      cmp("dedup_total",     got.dedup_total,     e.dedup_total);
      cmp("release_total",   got.release_total,   e.release_total);
      cmp("destroyed_total", got.destroyed_total, e.destroyed_total);
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  rdd_pkg::in_t                   in_word = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rdd_pkg::out_t                  out_word;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rdd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rdd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  desc_table_scoreboard sb = new();

  int unsigned  send_idle_pct = 0;   // chance per cycle that the sender holds off
  int unsigned  recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int unsigned  acq_pct = 35;
  int           pool_n = 12;
  rdd_pkg::in_t pool [POOL_MAX];
  int unsigned  cycles = 0;

  refcounted_descriptor_dedup_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycles <= cycles + 32'd1;
    if (cycles >= CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: values read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_word);
  end

  // Present one word and hold it until accepted. valid stays high afterwards;
  // the next call or the final idle decides whether it drops.
  task send_word(rdd_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
  endtask

  // Write one register, then deassert the valid before returning so that
  // back-to-back writes never assign the valid twice in one step.
  task write_cfg(logic [rdd_pkg::CFG_IDX_W-1:0] idx, logic [rdd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every owed word has come back, then let a scan finish.
  task drain();
    in_valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function rdd_pkg::in_t rand_desc();
    rdd_pkg::in_t w;
    w.operation           = rdd_pkg::OP_ACQUIRE;
    w.handle_in           = $urandom;
    w.mode_bytes          = {$urandom, $urandom};
    w.aniso_enable        = 1'($urandom_range(1));
    w.unnormalized_coords = 1'($urandom_range(1));
    w.lod_bias_bits       = $urandom;
    w.max_aniso_bits      = $urandom;
    w.min_lod_bits        = $urandom;
    w.max_lod_bits        = $urandom;
    return w;
  endfunction

  // Mostly reuse known descriptors, scrambling the fields that
  // canonicalization wipes so that equal-after-normalizing pairs show up.
  function rdd_pkg::in_t pick_desc();
    rdd_pkg::in_t w;
    if ($urandom_range(99) < 20) return rand_desc();
    w = pool[$urandom_range(pool_n - 1)];
    if (!w.aniso_enable && $urandom_range(1)) w.max_aniso_bits = $urandom;
    if (w.unnormalized_coords && $urandom_range(1)) begin
      w.mode_bytes[rdd_pkg::MIP_LSB +: 8] = 8'($urandom);
      w.min_lod_bits = $urandom;
      w.max_lod_bits = $urandom;
    end
    return w;
  endfunction

  function logic [31:0] pick_handle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return sb.live_handle();
    if (r < 80) return 32'd0;
    if (r < 90) return sb.next_handle - $urandom_range(3);
    return $urandom;
  endfunction

  function rdd_pkg::in_t rand_word();
    rdd_pkg::in_t w;
    int unsigned  r;
    w = pick_desc();
    w.handle_in = pick_handle();
    r = $urandom_range(99);
    if (r < acq_pct)            w.operation = rdd_pkg::OP_ACQUIRE;
    else if (r < acq_pct + 25)  w.operation = rdd_pkg::OP_RELEASE;
    else if (r < acq_pct + 33)  w.operation = rdd_pkg::OP_REFCOUNT;
    else if (r < acq_pct + 43)  w.operation = rdd_pkg::OP_EXISTS;
    else if (r < acq_pct + 51)  w.operation = rdd_pkg::OP_ENTRY;
    else if (r < acq_pct + 55)  w.operation = rdd_pkg::OP_PURGE;
    else if (r < 99)            w.operation = rdd_pkg::OP_STATS;
    else                        w.operation = rdd_pkg::OP_CLEAR;
    return w;
  endfunction

  function rdd_pkg::in_t with_op(rdd_pkg::in_t w, rdd_pkg::op_e op, logic [31:0] h);
    w.operation = op;
    w.handle_in = h;
    return w;
  endfunction

  task run_phase(int unsigned n_words, int unsigned mode);
    int unsigned idle_base, stall_base;
    case (mode)
      0: begin idle_base = 0;  stall_base = 0;  end
      1: begin idle_base = 62; stall_base = 0;  end
      2: begin idle_base = 0;  stall_base = 62; end
      default: begin idle_base = 30; stall_base = 30; end
    endcase
    for (int i = 0; i < pool_n; i++) pool[i] = rand_desc();
    for (int unsigned k = 0; k < n_words; k++) begin
      // drop back to no idling now and then for a stretch
      if (k % 100 >= 50 && k % 100 < 60) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct  = idle_base;
        recv_stall_pct = stall_base;
      end
      send_word(rand_word());
    end
    drain();
  endtask

  initial begin
    rdd_pkg::in_t d0, d1, d0_alias, zero_desc;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: canonical aliasing, hits, unknown handles, eviction, purge, clear.
    d0 = '1;
    d0.aniso_enable = 1'b0;
    d0.unnormalized_coords = 1'b1;
    d0_alias = d0;
    d0_alias.max_aniso_bits = '0;
    d0_alias.min_lod_bits = '0;
    d0_alias.max_lod_bits = 32'h1234_5678;
    d0_alias.mode_bytes[rdd_pkg::MIP_LSB +: 8] = 8'h00;
    zero_desc = '0;
    d1 = zero_desc;
    d1.aniso_enable = 1'b1;
    send_word(with_op(d0, rdd_pkg::OP_ACQUIRE, '0));
    send_word(with_op(d0_alias, rdd_pkg::OP_ACQUIRE, '0));
    send_word(with_op(zero_desc, rdd_pkg::OP_ACQUIRE, '0));
    send_word(with_op(d1, rdd_pkg::OP_ACQUIRE, '0));
    send_word(with_op(d0_alias, rdd_pkg::OP_EXISTS, '0));
    send_word(with_op(d1, rdd_pkg::OP_EXISTS, '1));
    send_word(with_op(zero_desc, rdd_pkg::OP_REFCOUNT, 32'd1));
    send_word(with_op(zero_desc, rdd_pkg::OP_ENTRY, 32'd2));
    send_word(with_op(zero_desc, rdd_pkg::OP_REFCOUNT, 32'd0));
    send_word(with_op(zero_desc, rdd_pkg::OP_ENTRY, '1));
    send_word(with_op(zero_desc, rdd_pkg::OP_RELEASE, 32'd1));
    send_word(with_op(zero_desc, rdd_pkg::OP_RELEASE, 32'd1));
    send_word(with_op(zero_desc, rdd_pkg::OP_RELEASE, 32'd1));
    send_word(with_op(zero_desc, rdd_pkg::OP_RELEASE, 32'd0));
    send_word(with_op(zero_desc, rdd_pkg::OP_PURGE, '0));
    send_word(with_op(zero_desc, rdd_pkg::OP_STATS, '0));
    send_word(with_op(d0, rdd_pkg::OP_ACQUIRE, '0));
    send_word(with_op(zero_desc, rdd_pkg::OP_CLEAR, '0));
    send_word(with_op(zero_desc, rdd_pkg::OP_STATS, '0));
    drain();

    // Table full with a zero capacity, then an unmapped register index.
    write_cfg(rdd_pkg::CFG_MAX_ENTRIES, {$urandom} & ~32'h7F);
    write_cfg(2'd3, $urandom);
    send_word(with_op(d1, rdd_pkg::OP_ACQUIRE, '0));
    send_word(with_op(d1, rdd_pkg::OP_EXISTS, '0));
    drain();

    // Random phases over a range of settings, extremes included.
    write_cfg(rdd_pkg::CFG_MAX_ENTRIES, 32'd64);
    run_phase(250, 0);

    write_cfg(rdd_pkg::CFG_MAX_ENTRIES, 32'd3);
    run_phase(250, 1);

    write_cfg(rdd_pkg::CFG_CANON, 32'hFFFF_FFFE);
    write_cfg(rdd_pkg::CFG_MAX_ENTRIES, 32'd1);
    run_phase(250, 2);

    // over-depth capacity with plenty of distinct descriptors: fill every slot
    write_cfg(rdd_pkg::CFG_MAX_ENTRIES, 32'h0000_007F);
    write_cfg(rdd_pkg::CFG_REF_COUNT, 32'd0);
    write_cfg(rdd_pkg::CFG_CANON, 32'd1);
    pool_n = 80;
    acq_pct = 40;
    run_phase(250, 3);

    write_cfg(rdd_pkg::CFG_REF_COUNT, 32'hFFFF_FFFF);
    run_phase(250, 1);

    write_cfg(rdd_pkg::CFG_MAX_ENTRIES, 32'd5);
    write_cfg(rdd_pkg::CFG_REF_COUNT, 32'd0);
    write_cfg(rdd_pkg::CFG_CANON, 32'd0);
    pool_n = 12;
    acq_pct = 35;
    run_phase(250, 2);

    write_cfg(rdd_pkg::CFG_MAX_ENTRIES, 32'd64);
    write_cfg(rdd_pkg::CFG_REF_COUNT, 32'd1);
    write_cfg(rdd_pkg::CFG_CANON, 32'd1);
    run_phase(230, 3);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
